// ===== rtl/core/mwm_pkg.sv =====
// shared types and constants for the mecanum wheel mixer
`default_nettype none
package mwm_pkg;

    localparam int WHEELS = 4;

    // quotient bits of the wheel scaling and duty dividers
    localparam int SCALE_BITS = 15;
    localparam int DUTY_BITS = 8;

    // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for x below 2^27
    localparam logic [27:0] RECIP_1000 = 28'd137438954;
    localparam int RECIP_SHIFT = 37;

    localparam logic [DUTY_BITS-1:0] DUTY_FULL = 8'd255;
    localparam logic signed [15:0] S16_MAX = 16'sh7fff;
    localparam logic signed [15:0] S16_MIN = -16'sh8000;

    typedef logic signed [18:0] wheel_t;
    typedef logic [17:0] wheel_mag_t;
    typedef logic signed [15:0] speed_t;
    typedef logic signed [8:0] duty_t;

    typedef enum logic [1:0] {
        REG_TRACK_WIDTH = 2'd0,
        REG_WHEEL_BASE  = 2'd1,
        REG_MAX_SPEED   = 2'd2,
        REG_MIN_DUTY    = 2'd3
    } cfg_index_t;

endpackage
`default_nettype wire

// ===== rtl/core/mwm_kin.sv =====
// rotation term, wheel speeds and peak magnitude, six register stages
`default_nettype none
module mwm_kin
    import mwm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire speed_t      vx,
    input  wire speed_t      vy,
    input  wire speed_t      rate,
    input  wire logic [11:0] half_sum,
    output logic             out_valid,
    output wheel_t           w [WHEELS],
    output wheel_mag_t       peak
);

    logic [5:0] valid_reg;

    logic signed [28:0] prod1_reg;
    speed_t vx1_reg, vy1_reg, vx2_reg, vy2_reg, vx3_reg, vy3_reg;
    logic neg2_reg, neg3_reg;
    logic [26:0] mag2_reg;
    logic [17:0] rot3_reg;
    wheel_t w4_reg [WHEELS];
    wheel_t w5_reg [WHEELS];
    wheel_t w6_reg [WHEELS];
    wheel_mag_t abs5_reg [WHEELS];
    wheel_mag_t peak6_reg;

    logic [28:0] prod_abs;
    logic [54:0] recip_prod;
    wheel_t rot;
    wheel_t vx_w, vy_w;
    wheel_t w_abs [WHEELS];
    wheel_mag_t max_a, max_b;

    always_comb
    begin
        prod_abs = prod1_reg[28] ? 29'(-prod1_reg) : 29'(prod1_reg);
        recip_prod = 55'(mag2_reg) * 55'(RECIP_1000);
        rot = neg3_reg ? -$signed({1'b0, rot3_reg}) : $signed({1'b0, rot3_reg});
        vx_w = 19'(vx3_reg);
        vy_w = 19'(vy3_reg);
        for (int j = 0; j < WHEELS; j++)
        begin
            w_abs[j] = w4_reg[j][18] ? -w4_reg[j] : w4_reg[j];
        end
        max_a = (abs5_reg[0] > abs5_reg[1]) ? abs5_reg[0] : abs5_reg[1];
        max_b = (abs5_reg[2] > abs5_reg[3]) ? abs5_reg[2] : abs5_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= $signed(rate) * $signed({1'b0, half_sum});
        vx1_reg <= vx;
        vy1_reg <= vy;

        neg2_reg <= prod1_reg[28];
        mag2_reg <= prod_abs[26:0];
        vx2_reg <= vx1_reg;
        vy2_reg <= vy1_reg;

        neg3_reg <= neg2_reg;
        rot3_reg <= recip_prod[RECIP_SHIFT +: 18];
        vx3_reg <= vx2_reg;
        vy3_reg <= vy2_reg;

        w4_reg[0] <= vx_w - vy_w - rot;
        w4_reg[1] <= vx_w + vy_w + rot;
        w4_reg[2] <= vx_w + vy_w - rot;
        w4_reg[3] <= vx_w - vy_w + rot;

        for (int j = 0; j < WHEELS; j++)
        begin
            abs5_reg[j] <= w_abs[j][17:0];
            w5_reg[j] <= w4_reg[j];
            w6_reg[j] <= w5_reg[j];
        end
        peak6_reg <= (max_a > max_b) ? max_a : max_b;
    end

    assign out_valid = valid_reg[5];
    assign w = w6_reg;
    assign peak = peak6_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mwm_scale.sv =====
// peak limiting: w * max / peak by a one bit per stage divider, else 16 bit clamp
`default_nettype none
module mwm_scale
    import mwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire wheel_t                w [WHEELS],
    input  wire wheel_mag_t            peak,
    input  wire logic [SCALE_BITS-1:0] max_speed,
    output logic                       out_valid,
    output speed_t                     speed [WHEELS]
);

    logic [SCALE_BITS:0] valid_reg;
    logic out_valid_reg;
    logic [SCALE_BITS:0] scale_reg;
    logic [32:0] rem_reg [SCALE_BITS+1][WHEELS];
    logic [SCALE_BITS-1:0] q_reg [SCALE_BITS+1][WHEELS];
    wheel_t w_reg [SCALE_BITS+1][WHEELS];
    wheel_mag_t den_reg [SCALE_BITS+1];
    speed_t speed_reg [WHEELS];

    wheel_t w_abs [WHEELS];
    logic [32:0] trial [1:SCALE_BITS][WHEELS];
    speed_t speed_next [WHEELS];
    wheel_t last_w;
    logic [SCALE_BITS-1:0] last_q;

    always_comb
    begin
        last_w = '0;
        last_q = '0;
        for (int j = 0; j < WHEELS; j++)
        begin
            w_abs[j] = w[j][18] ? -w[j] : w[j];
        end
        for (int k = 1; k <= SCALE_BITS; k++)
        begin
            for (int j = 0; j < WHEELS; j++)
            begin
                trial[k][j] = 33'(den_reg[k-1]) << (SCALE_BITS - k);
            end
        end
        for (int j = 0; j < WHEELS; j++)
        begin
            last_w = w_reg[SCALE_BITS][j];
            last_q = q_reg[SCALE_BITS][j];
            if (scale_reg[SCALE_BITS])
            begin
                speed_next[j] = last_w[18] ? -$signed({1'b0, last_q})
                                           : $signed({1'b0, last_q});
            end
            else if (last_w > 19'(S16_MAX))
            begin
                speed_next[j] = S16_MAX;
            end
            else if (last_w < 19'(S16_MIN))
            begin
                speed_next[j] = S16_MIN;
            end
            else
            begin
                speed_next[j] = last_w[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[SCALE_BITS-1:0], in_valid};
            out_valid_reg <= valid_reg[SCALE_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg[0] <= (max_speed != '0) && (peak > 18'(max_speed));
        den_reg[0] <= peak;
        for (int j = 0; j < WHEELS; j++)
        begin
            rem_reg[0][j] <= 33'(w_abs[j][17:0]) * 33'(max_speed);
            q_reg[0][j] <= '0;
            w_reg[0][j] <= w[j];
        end
        // restoring division, quotient bit SCALE_BITS-k in stage k
        for (int k = 1; k <= SCALE_BITS; k++)
        begin
            scale_reg[k] <= scale_reg[k-1];
            den_reg[k] <= den_reg[k-1];
            for (int j = 0; j < WHEELS; j++)
            begin
                w_reg[k][j] <= w_reg[k-1][j];
                if (rem_reg[k-1][j] >= trial[k][j])
                begin
                    rem_reg[k][j] <= rem_reg[k-1][j] - trial[k][j];
                    q_reg[k][j] <= q_reg[k-1][j] | (SCALE_BITS'(1) << (SCALE_BITS - k));
                end
                else
                begin
                    rem_reg[k][j] <= rem_reg[k-1][j];
                    q_reg[k][j] <= q_reg[k-1][j];
                end
            end
        end
        for (int j = 0; j < WHEELS; j++)
        begin
            speed_reg[j] <= speed_next[j];
        end
    end

    assign out_valid = out_valid_reg;
    assign speed = speed_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mwm_duty.sv =====
// duty = speed * 255 / max with saturation and floor, one quotient bit per stage
`default_nettype none
module mwm_duty
    import mwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire speed_t                speed_in [WHEELS],
    input  wire logic [SCALE_BITS-1:0] max_speed,
    input  wire logic [DUTY_BITS-1:0]  min_duty,
    output logic                       out_valid,
    output speed_t                     speed [WHEELS],
    output duty_t                      duty [WHEELS]
);

    logic [DUTY_BITS:0] valid_reg;
    logic out_valid_reg;
    logic [22:0] rem_reg [DUTY_BITS+1][WHEELS];
    logic [DUTY_BITS-1:0] q_reg [DUTY_BITS+1][WHEELS];
    logic [DUTY_BITS:0] sat_reg [WHEELS];
    logic [DUTY_BITS:0] zero_reg [WHEELS];
    speed_t s_reg [DUTY_BITS+1][WHEELS];
    speed_t speed_reg [WHEELS];
    duty_t duty_reg [WHEELS];

    logic [15:0] s_abs [WHEELS];
    logic [22:0] dvd [WHEELS];
    logic [22:0] trial [1:DUTY_BITS];
    logic [DUTY_BITS-1:0] mag [WHEELS];
    duty_t duty_next [WHEELS];

    always_comb
    begin
        for (int j = 0; j < WHEELS; j++)
        begin
            s_abs[j] = speed_in[j][15] ? 16'(-speed_in[j]) : 16'(speed_in[j]);
            dvd[j] = 23'({s_abs[j], 8'b0} - {8'b0, s_abs[j]});
        end
        for (int k = 1; k <= DUTY_BITS; k++)
        begin
            trial[k] = 23'(max_speed) << (DUTY_BITS - k);
        end
        for (int j = 0; j < WHEELS; j++)
        begin
            mag[j] = sat_reg[j][DUTY_BITS] ? DUTY_FULL : q_reg[DUTY_BITS][j];
            // a small nonzero duty is raised to the floor
            if (mag[j] != '0 && mag[j] < min_duty)
            begin
                mag[j] = min_duty;
            end
            if (zero_reg[j][DUTY_BITS])
            begin
                duty_next[j] = '0;
            end
            else
            begin
                duty_next[j] = s_reg[DUTY_BITS][j][15] ? -$signed({1'b0, mag[j]})
                                                       : $signed({1'b0, mag[j]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[DUTY_BITS-1:0], in_valid};
            out_valid_reg <= valid_reg[DUTY_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < WHEELS; j++)
        begin
            rem_reg[0][j] <= dvd[j];
            q_reg[0][j] <= '0;
            s_reg[0][j] <= speed_in[j];
            sat_reg[j][0] <= dvd[j] >= {max_speed, 8'b0};
            zero_reg[j][0] <= (speed_in[j] == '0) || (max_speed == '0);
            for (int k = 1; k <= DUTY_BITS; k++)
            begin
                s_reg[k][j] <= s_reg[k-1][j];
                sat_reg[j][k] <= sat_reg[j][k-1];
                zero_reg[j][k] <= zero_reg[j][k-1];
                if (rem_reg[k-1][j] >= trial[k])
                begin
                    rem_reg[k][j] <= rem_reg[k-1][j] - trial[k];
                    q_reg[k][j] <= q_reg[k-1][j] | (DUTY_BITS'(1) << (DUTY_BITS - k));
                end
                else
                begin
                    rem_reg[k][j] <= rem_reg[k-1][j];
                    q_reg[k][j] <= q_reg[k-1][j];
                end
            end
            speed_reg[j] <= s_reg[DUTY_BITS][j];
            duty_reg[j] <= duty_next[j];
        end
    end

    assign out_valid = out_valid_reg;
    assign speed = speed_reg;
    assign duty = duty_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mecanum_wheel_mixer.sv =====
// mecanum wheel mixer top level: config registers, input stage and pipeline
//
//  port group      dir  handshake        payload
//  command         in   start / busy     forward_speed, lateral_speed, turn_rate
//  wheel result    out  done strobe      *_speed, *_duty (four wheels)
//  config write    in   cfg_we           cfg_index, cfg_data
//
// one command transfer per cycle; busy is always low
// done follows the command transfer through 34 register stages, set by
// the 15 stage scaling divider and the 8 stage duty divider, one quotient bit per stage
// reset clears config registers to zero and drops every item in flight
// results cannot be held off, so the pipeline never stalls
`default_nettype none
module mecanum_wheel_mixer
    import mwm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire speed_t      forward_speed,
    input  wire speed_t      lateral_speed,
    input  wire speed_t      turn_rate,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    output logic             done,
    output speed_t           front_left_speed,
    output speed_t           front_right_speed,
    output speed_t           rear_left_speed,
    output speed_t           rear_right_speed,
    output duty_t            front_left_duty,
    output duty_t            front_right_duty,
    output duty_t            rear_left_duty,
    output duty_t            rear_right_duty
);

    logic [11:0] track_width_reg;
    logic [11:0] wheel_base_reg;
    logic [SCALE_BITS-1:0] max_speed_reg;
    logic [DUTY_BITS-1:0] min_duty_reg;

    logic in_valid_reg;
    speed_t vx_reg, vy_reg, rate_reg;

    logic [12:0] geo_sum;
    logic kin_valid, scale_valid, duty_valid;
    wheel_t kin_w [WHEELS];
    wheel_mag_t kin_peak;
    speed_t scale_speed [WHEELS];
    speed_t out_speed [WHEELS];
    duty_t out_duty [WHEELS];

    assign geo_sum = {1'b0, track_width_reg} + {1'b0, wheel_base_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_width_reg <= '0;
            wheel_base_reg <= '0;
            max_speed_reg <= '0;
            min_duty_reg <= '0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRACK_WIDTH: track_width_reg <= cfg_data[11:0];
                    REG_WHEEL_BASE:  wheel_base_reg <= cfg_data[11:0];
                    REG_MAX_SPEED:   max_speed_reg <= cfg_data;
                    REG_MIN_DUTY:    min_duty_reg <= cfg_data[7:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg <= forward_speed;
        vy_reg <= lateral_speed;
        rate_reg <= turn_rate;
    end

    mwm_kin u_kin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .vx        (vx_reg),
        .vy        (vy_reg),
        .rate      (rate_reg),
        .half_sum  (geo_sum[12:1]),
        .out_valid (kin_valid),
        .w         (kin_w),
        .peak      (kin_peak)
    );

    mwm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (kin_valid),
        .w         (kin_w),
        .peak      (kin_peak),
        .max_speed (max_speed_reg),
        .out_valid (scale_valid),
        .speed     (scale_speed)
    );

    mwm_duty u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .speed_in  (scale_speed),
        .max_speed (max_speed_reg),
        .min_duty  (min_duty_reg),
        .out_valid (duty_valid),
        .speed     (out_speed),
        .duty      (out_duty)
    );

    assign busy = 1'b0;
    assign done = duty_valid;
    assign front_left_speed = out_speed[0];
    assign front_right_speed = out_speed[1];
    assign rear_left_speed = out_speed[2];
    assign rear_right_speed = out_speed[3];
    assign front_left_duty = out_duty[0];
    assign front_right_duty = out_duty[1];
    assign rear_left_duty = out_duty[2];
    assign rear_right_duty = out_duty[3];

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (front_left_duty != -9'sd256 && front_right_duty != -9'sd256 &&
                  rear_left_duty != -9'sd256 && rear_right_duty != -9'sd256))
        else $error("duty outside +-255");

    a_zero_max: assert property (@(posedge clk) disable iff (!rst_n)
        (done && max_speed_reg == '0) |->
            (front_left_duty == '0 && front_right_duty == '0 &&
             rear_left_duty == '0 && rear_right_duty == '0))
        else $error("nonzero duty with zero max speed");

    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && front_left_speed == '0) |-> front_left_duty == '0)
        else $error("nonzero duty for a stopped wheel");

    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (done && front_right_duty != '0) |->
            (front_right_duty[8] == front_right_speed[15]))
        else $error("duty sign differs from speed sign");
`endif

endmodule
`default_nettype wire
